// File: rtl/core/efsc_pkg.sv
// Shared types and constants for the Ethernet frame statistics counters.
// Used by the front classifier, the request queue, the counter back end and the top level.
package efsc_pkg;

  localparam int unsigned NUM_COUNTERS        = 14;
  localparam int unsigned IDX_W               = 4;
  localparam int unsigned LEN_W               = 16;
  localparam int unsigned VALUE_W             = 48;
  localparam int unsigned COUNT_WIDTH_DEFAULT = 48;
  localparam int unsigned QUEUE_DEPTH         = 4;

  // Counter indexes.
  localparam int unsigned CNT_ARP       = 0;
  localparam int unsigned CNT_IPV4      = 1;
  localparam int unsigned CNT_IPV6      = 2;
  localparam int unsigned CNT_VLAN      = 3;
  localparam int unsigned CNT_RUNT      = 4;
  localparam int unsigned CNT_JUMBO     = 5;
  localparam int unsigned CNT_LEN64     = 6;
  localparam int unsigned CNT_65_127    = 7;
  localparam int unsigned CNT_128_255   = 8;
  localparam int unsigned CNT_256_511   = 9;
  localparam int unsigned CNT_512_1023  = 10;
  localparam int unsigned CNT_1024_1518 = 11;
  localparam int unsigned CNT_BCAST     = 12;
  localparam int unsigned CNT_MCAST     = 13;

  // Request opcodes.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // EtherType values.
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;

  // On-wire length limits and bin edges.
  localparam logic [LEN_W-1:0] FCS_LEN   = 16'd4;
  localparam logic [LEN_W-1:0] MIN_FRAME = 16'd64;
  localparam logic [LEN_W-1:0] MAX_FRAME = 16'd1518;
  localparam logic [LEN_W-1:0] EDGE_127  = 16'd127;
  localparam logic [LEN_W-1:0] EDGE_255  = 16'd255;
  localparam logic [LEN_W-1:0] EDGE_511  = 16'd511;
  localparam logic [LEN_W-1:0] EDGE_1023 = 16'd1023;

  localparam logic [7:0] BCAST_BYTE = 8'hFF;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic                    is_read;
    logic [NUM_COUNTERS-1:0] inc_mask;
    logic [IDX_W-1:0]        idx;
  } q_entry_t;

endpackage

// File: rtl/core/efsc_front.sv
// Front classifier: turns an incoming request into a counter increment mask or a read.
// Depends on efsc_pkg for counter indexes, EtherType codes and the queue entry type.
module efsc_front (
  input  logic                      op,
  input  logic [15:0]               eth_type,
  input  logic [efsc_pkg::LEN_W-1:0] frame_len,
  input  logic [7:0]                dest_byte0,
  input  logic [7:0]                dest_byte1,
  input  logic [efsc_pkg::IDX_W-1:0] counter_index,
  output efsc_pkg::q_entry_t        entry
);

  logic [efsc_pkg::LEN_W-1:0]        wire_len;
  logic [efsc_pkg::NUM_COUNTERS-1:0] mask;

  // The length sum stays 16 bits wide, so the largest lengths wrap into the runt bin.
  assign wire_len = frame_len + efsc_pkg::FCS_LEN;

  always_comb begin
    mask = '0;
    case (eth_type)
      efsc_pkg::ETYPE_ARP:  mask[efsc_pkg::CNT_ARP]  = 1'b1;
      efsc_pkg::ETYPE_IPV4: mask[efsc_pkg::CNT_IPV4] = 1'b1;
      efsc_pkg::ETYPE_IPV6: mask[efsc_pkg::CNT_IPV6] = 1'b1;
      efsc_pkg::ETYPE_VLAN: mask[efsc_pkg::CNT_VLAN] = 1'b1;
      default: ;
    endcase

    if (wire_len < efsc_pkg::MIN_FRAME) begin
      mask[efsc_pkg::CNT_RUNT] = 1'b1;
    end else if (wire_len > efsc_pkg::MAX_FRAME) begin
      mask[efsc_pkg::CNT_JUMBO] = 1'b1;
    end else if (wire_len == efsc_pkg::MIN_FRAME) begin
      mask[efsc_pkg::CNT_LEN64] = 1'b1;
    end else if (wire_len <= efsc_pkg::EDGE_127) begin
      mask[efsc_pkg::CNT_65_127] = 1'b1;
    end else if (wire_len <= efsc_pkg::EDGE_255) begin
      mask[efsc_pkg::CNT_128_255] = 1'b1;
    end else if (wire_len <= efsc_pkg::EDGE_511) begin
      mask[efsc_pkg::CNT_256_511] = 1'b1;
    end else if (wire_len <= efsc_pkg::EDGE_1023) begin
      mask[efsc_pkg::CNT_512_1023] = 1'b1;
    end else begin
      mask[efsc_pkg::CNT_1024_1518] = 1'b1;
    end

    if (dest_byte0[0]) begin
      if (dest_byte0 == efsc_pkg::BCAST_BYTE && dest_byte1 == efsc_pkg::BCAST_BYTE) begin
        mask[efsc_pkg::CNT_BCAST] = 1'b1;
      end else begin
        mask[efsc_pkg::CNT_MCAST] = 1'b1;
      end
    end
  end

  always_comb begin
    entry.is_read  = (op == efsc_pkg::OP_READ);
    entry.inc_mask = entry.is_read ? '0 : mask;
    entry.idx      = counter_index;
  end

endmodule

// File: rtl/core/efsc_queue.sv
// Short request queue between the classifier and the counter back end.
// Depends on efsc_pkg for the entry type and the queue depth.
module efsc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  efsc_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output efsc_pkg::q_entry_t head_entry
);

  localparam int unsigned DEPTH = efsc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  efsc_pkg::q_entry_t slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/core/efsc_back.sv
// Counter back end: applies increment masks to the counter bank and serves reads.
// Depends on efsc_pkg for the entry type and counter count.
module efsc_back #(
  parameter int unsigned COUNT_WIDTH = efsc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  efsc_pkg::q_entry_t          head_entry,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [efsc_pkg::VALUE_W-1:0] out_value
);

  localparam int unsigned NUM = efsc_pkg::NUM_COUNTERS;
  localparam int unsigned OW  = efsc_pkg::VALUE_W;

  logic [COUNT_WIDTH-1:0]    counters_r [NUM];
  logic [COUNT_WIDTH-1:0]    counters_nxt [NUM];
  logic                      out_valid_r, out_valid_nxt;
  logic [OW-1:0]             out_value_r;
  logic [COUNT_WIDTH-1:0]    sel_count;
  logic [OW+COUNT_WIDTH-1:0] sel_ext;
  logic                      do_read;

  // A frame never waits on the output; a read waits only while a held result is stalled.
  assign pop     = head_valid && (!head_entry.is_read || !out_valid_r || !out_stall);
  assign do_read = pop && head_entry.is_read;

  always_comb begin
    for (int i = 0; i < NUM; i++) begin
      counters_nxt[i] = counters_r[i];
      if (pop && head_entry.inc_mask[i]) begin
        counters_nxt[i] = counters_r[i] + COUNT_WIDTH'(1);
      end
    end
  end

  // Unused indexes read as zero; the result carries the low bits of the counter.
  always_comb begin
    if (head_entry.idx < efsc_pkg::IDX_W'(NUM)) begin
      sel_count = counters_r[head_entry.idx];
    end else begin
      sel_count = '0;
    end
    sel_ext = {OW'(0), sel_count};
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || do_read;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM; i++) begin
        counters_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM; i++) begin
        counters_r[i] <= counters_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      out_value_r <= sel_ext[OW-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

// File: rtl/core/ethernet_frame_statistics_counters_core.sv
// Top level of the Ethernet frame statistics counters.
// Depends on efsc_pkg, efsc_front, efsc_queue and efsc_back.
//
// Keeps fourteen RMON-style receive counters (EtherType, size bin, broadcast and
// multicast), cleared by reset and wrapping at COUNT_WIDTH bits. A frame request
// (op 0) bumps up to three counters and returns nothing; a read request (op 1)
// returns one counter value, or zero for an index beyond the last counter. The
// block takes one request per cycle: the classifier writes into a four-entry queue,
// and the counter bank retires one queued request per cycle unless a read waits on
// a stalled result, all counters of a frame updating in parallel. A read result
// passes through the queue and sits in an output register; while it is stalled,
// frames keep retiring and only the next read waits, so the input stalls only
// once the queue fills. Reads always see every frame taken before them.
module ethernet_frame_statistics_counters_core #(
  parameter int unsigned COUNT_WIDTH = efsc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [15:0]                  in_eth_type,
  input  logic [15:0]                  in_frame_len,
  input  logic [7:0]                   in_dest_byte0,
  input  logic [7:0]                   in_dest_byte1,
  input  logic [3:0]                   in_counter_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [efsc_pkg::VALUE_W-1:0] out_counter_value
);

  efsc_pkg::q_entry_t new_entry;
  efsc_pkg::q_entry_t head_entry;
  logic               q_full;
  logic               push;
  logic               pop;
  logic               head_valid;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  efsc_front u_front (
    .op            (in_op),
    .eth_type      (in_eth_type),
    .frame_len     (in_frame_len),
    .dest_byte0    (in_dest_byte0),
    .dest_byte1    (in_dest_byte1),
    .counter_index (in_counter_index),
    .entry         (new_entry)
  );

  efsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (new_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  efsc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_counter_value)
  );

endmodule
